/* hw/rtl/link_telemetry_ema_smoother_defines.svh */
// ============================================================================
// Link telemetry smoother assertion macros
// Shared concurrent assertion forms, clocked on clk_i and muted during reset.
// ============================================================================
`ifndef LINK_TELEMETRY_EMA_SMOOTHER_DEFINES_SVH
`define LINK_TELEMETRY_EMA_SMOOTHER_DEFINES_SVH

// Same-cycle implication.
`define LTES_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LTES_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ltes_pkg.sv */
// ============================================================================
// Link telemetry smoother package
// Widths, constants and shared types of the smoother front and back ends.
// ============================================================================
package ltes_pkg;

  // Field widths.
  localparam int LOSS_W   = 16;
  localparam int JIT_W    = 20;
  localparam int RTT_W    = 20;
  localparam int BW_W     = 32;
  localparam int LPCT_W   = 15;
  localparam int ALPHA_W  = 16;

  // Fraction bits of the smoothing weight.
  localparam int ALPHA_BITS = 16;

  // Common metric datapath width and multiplier widths.
  localparam int EST_W  = 32;
  localparam int PROD_W = ALPHA_W + EST_W;
  localparam int STEP_W = PROD_W - ALPHA_BITS;
  localparam int SUM_W  = ((STEP_W > EST_W) ? STEP_W : EST_W) + 1;

  // Bits per kilobit per second scaling and loss percentage scaling.
  localparam logic [ALPHA_W-1:0] BW_SCALE       = ALPHA_W'(8000);
  localparam int                 LPCT_SUM_W     = 24;
  localparam logic [LPCT_SUM_W-1:0] LPCT_SCALE  = LPCT_SUM_W'(100);
  localparam logic [LPCT_SUM_W-1:0] LPCT_ROUND  = LPCT_SUM_W'(128);
  localparam int                 LPCT_SHIFT     = 8;

  // Reset value of the smoothing weight.
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(13107);

  // Divider iterations and counter width.
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Queue between front and back ends.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_kind_e;

  // One classified item as it sits in the queue.
  typedef struct packed {
    cmd_kind_e           kind;
    logic                zero_iv;
    logic [LOSS_W-1:0]   loss;
    logic [JIT_W-1:0]    jitter;
    logic [RTT_W-1:0]    rtt;
    logic [BW_W-1:0]     bytes;
    logic [BW_W-1:0]     us;
  } cmd_t;

  // Queue head status seen by the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BWMUL,
    ST_BWCHK,
    ST_DIV,
    ST_UPD,
    ST_EMUL,
    ST_EAPPLY,
    ST_EMIT
  } back_state_e;

  typedef enum logic [1:0] {
    MET_LOSS,
    MET_JITTER,
    MET_RTT,
    MET_BW
  } metric_e;

endpackage

/* hw/rtl/link_telemetry_ema_smoother.sv */
// ============================================================================
// Link telemetry smoother
// Exponential moving average of loss, jitter, round-trip time and bandwidth.
// ============================================================================
//
//   Channel   Signals                                    Direction
//   -------   ----------------------------------------   ---------
//   in        in_valid_i / in_stall_o, six field ports   sink
//   out       out_valid_o / out_stall_i, four fields     source
//   alpha     alpha_we_i, alpha_wdata_i                  write only
//
// In the back end a sample passes through the bandwidth multiply, a range
// check, 32 steps of the restoring divider and the four weighted updates on
// the shared multiplier. A zero interval or a saturated bandwidth skips the
// divider, a seeding sample skips the updates, and a clear goes to the output.
// A two-item queue lets the front accept while the back works or the output
// register waits. Reset clears the estimates and re-arms seeding at once.
//
module link_telemetry_ema_smoother (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        alpha_we_i,
  input  logic [15:0] alpha_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        clear_i,
  input  logic [15:0] loss_rate_i,
  input  logic [19:0] jitter_i,
  input  logic [19:0] rtt_i,
  input  logic [31:0] bytes_received_i,
  input  logic [31:0] interval_us_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [14:0] loss_pct_o,
  output logic [19:0] jitter_est_o,
  output logic [19:0] rtt_est_o,
  output logic [31:0] bandwidth_kbps_o
);
  import ltes_pkg::*;

  q_head_t head;
  logic    pop;

  // Accept and queue items.
  ltes_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .clear_i          (clear_i),
    .loss_rate_i      (loss_rate_i),
    .jitter_i         (jitter_i),
    .rtt_i            (rtt_i),
    .bytes_received_i (bytes_received_i),
    .interval_us_i    (interval_us_i),
    .pop_i            (pop),
    .head_o           (head)
  );

  // Compute and present results.
  ltes_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .alpha_we_i       (alpha_we_i),
    .alpha_wdata_i    (alpha_wdata_i),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .loss_pct_o       (loss_pct_o),
    .jitter_est_o     (jitter_est_o),
    .rtt_est_o        (rtt_est_o),
    .bandwidth_kbps_o (bandwidth_kbps_o)
  );

endmodule

/* hw/rtl/ltes_front.sv */
// ============================================================================
// Link telemetry smoother front end
// Accepts items, classifies them and holds them in a short queue.
// ============================================================================
module ltes_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     clear_i,
  input  logic [15:0]              loss_rate_i,
  input  logic [19:0]              jitter_i,
  input  logic [19:0]              rtt_i,
  input  logic [31:0]              bytes_received_i,
  input  logic [31:0]              interval_us_i,
  input  logic                     pop_i,
  output ltes_pkg::q_head_t        head_o
);
  import ltes_pkg::*;

  cmd_t                 mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;
  logic                 push;
  cmd_t                 cmd_in;

  // Classify the incoming item.
  always_comb begin
    cmd_in.kind    = clear_i ? CMD_CLEAR : CMD_SAMPLE;
    cmd_in.zero_iv = (interval_us_i == '0);
    cmd_in.loss    = loss_rate_i;
    cmd_in.jitter  = jitter_i;
    cmd_in.rtt     = rtt_i;
    cmd_in.bytes   = bytes_received_i;
    cmd_in.us      = interval_us_i;
  end

  // Accept while the queue has room.
  assign in_stall_o = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign push       = in_valid_i && !in_stall_o;

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

endmodule

/* hw/rtl/ltes_back.sv */
// ============================================================================
// Link telemetry smoother back end
// Computes the bandwidth sample and updates the four moving averages.
// ============================================================================
`include "link_telemetry_ema_smoother_defines.svh"

module ltes_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     alpha_we_i,
  input  logic [15:0]              alpha_wdata_i,
  input  ltes_pkg::q_head_t        head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [14:0]              loss_pct_o,
  output logic [19:0]              jitter_est_o,
  output logic [19:0]              rtt_est_o,
  output logic [31:0]              bandwidth_kbps_o
);
  import ltes_pkg::*;

  back_state_e            state_q, state_d;
  metric_e                idx_q, idx_d;
  logic [DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic                   first_q;
  logic [ALPHA_W-1:0]     alpha_q;
  logic [LOSS_W-1:0]      loss_est_q;
  logic [JIT_W-1:0]       jit_est_q;
  logic [RTT_W-1:0]       rtt_est_q;
  logic [BW_W-1:0]        bw_est_q;
  logic                   out_valid_q;

  cmd_t                   cmd_q;
  logic [PROD_W-1:0]      prod_q;
  logic [EST_W-1:0]       rem_q;
  logic [EST_W-1:0]       quo_q;
  logic [BW_W-1:0]        bw_smp_q;
  logic [LPCT_W-1:0]      loss_pct_q;
  logic [JIT_W-1:0]       jit_out_q;
  logic [RTT_W-1:0]       rtt_out_q;
  logic [BW_W-1:0]        bw_out_q;

  logic                   out_free;
  logic [ALPHA_W-1:0]     mul_a;
  logic [EST_W-1:0]       mul_b;
  logic [PROD_W-1:0]      prod_d;
  logic [EST_W:0]         rem_shift;
  logic                   div_bit;
  logic [EST_W-1:0]       rem_next;
  logic [EST_W-1:0]       quo_next;
  logic [EST_W-1:0]       bw_high;
  logic [EST_W-1:0]       sel_est, sel_smp, sel_max;
  logic                   smp_ge;
  logic [EST_W-1:0]       abs_d;
  logic [SUM_W-1:0]       est_ext, step_ext, sum_up;
  logic [EST_W-1:0]       new_val;
  logic [LPCT_SUM_W-1:0]  lpct_sum;

  assign out_free = !out_valid_q || !out_stall_i;

  // Select the metric under update.
  always_comb begin
    case (idx_q)
      MET_LOSS: begin
        sel_est = EST_W'(loss_est_q);
        sel_smp = EST_W'(cmd_q.loss);
        sel_max = EST_W'({LOSS_W{1'b1}});
      end
      MET_JITTER: begin
        sel_est = EST_W'(jit_est_q);
        sel_smp = EST_W'(cmd_q.jitter);
        sel_max = EST_W'({JIT_W{1'b1}});
      end
      MET_RTT: begin
        sel_est = EST_W'(rtt_est_q);
        sel_smp = EST_W'(cmd_q.rtt);
        sel_max = EST_W'({RTT_W{1'b1}});
      end
      MET_BW: begin
        sel_est = EST_W'(bw_est_q);
        sel_smp = EST_W'(bw_smp_q);
        sel_max = EST_W'({BW_W{1'b1}});
      end
      default: begin
        sel_est = '0;
        sel_smp = '0;
        sel_max = '0;
      end
    endcase
  end

  assign smp_ge = (sel_smp >= sel_est);
  assign abs_d  = smp_ge ? (sel_smp - sel_est) : (sel_est - sel_smp);

  // Shared multiplier: bandwidth scaling, then one weighted difference a pass.
  assign mul_a  = (state_q == ST_BWMUL) ? BW_SCALE : alpha_q;
  assign mul_b  = (state_q == ST_BWMUL) ? EST_W'(cmd_q.bytes) : abs_d;
  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Move the estimate toward the sample, clamped to the field.
  always_comb begin
    est_ext  = SUM_W'(sel_est);
    step_ext = SUM_W'(prod_q[PROD_W-1:ALPHA_BITS]);
    sum_up   = est_ext + step_ext;
    if (smp_ge) begin
      new_val = (sum_up > SUM_W'(sel_max)) ? sel_max : sum_up[EST_W-1:0];
    end else begin
      new_val = (step_ext >= est_ext) ? '0 : EST_W'(est_ext - step_ext);
    end
  end

  // One restoring division step per cycle.
  assign bw_high   = EST_W'(prod_q[PROD_W-1:EST_W]);
  assign rem_shift = {rem_q, quo_q[EST_W-1]};
  assign div_bit   = (rem_shift >= {1'b0, cmd_q.us});
  assign rem_next  = div_bit ? EST_W'(rem_shift - {1'b0, cmd_q.us})
                             : rem_shift[EST_W-1:0];
  assign quo_next  = {quo_q[EST_W-2:0], div_bit};

  // Loss percentage with rounding, in 1/256 percent.
  assign lpct_sum = LPCT_SUM_W'(loss_est_q) * LPCT_SCALE + LPCT_ROUND;

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    pop_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          state_d = (head_i.cmd.kind == CMD_CLEAR) ? ST_EMIT : ST_BWMUL;
        end
      end
      ST_BWMUL: begin
        state_d = ST_BWCHK;
      end
      ST_BWCHK: begin
        if (cmd_q.zero_iv || (bw_high >= cmd_q.us)) begin
          state_d = ST_UPD;
        end else begin
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        idx_d   = MET_LOSS;
        state_d = first_q ? ST_EMIT : ST_EMUL;
      end
      ST_EMUL: begin
        state_d = ST_EAPPLY;
      end
      ST_EAPPLY: begin
        if (idx_q == MET_BW) begin
          state_d = ST_EMIT;
        end else begin
          idx_d   = metric_e'(idx_q + 1'b1);
          state_d = ST_EMUL;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and architectural estimates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= MET_LOSS;
      cnt_q       <= '0;
      first_q     <= 1'b1;
      alpha_q     <= ALPHA_RESET;
      loss_est_q  <= '0;
      jit_est_q   <= '0;
      rtt_est_q   <= '0;
      bw_est_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      if (alpha_we_i) begin
        alpha_q <= alpha_wdata_i;
      end
      // A clear zeroes every estimate and re-arms seeding.
      if (pop_o && (head_i.cmd.kind == CMD_CLEAR)) begin
        first_q    <= 1'b1;
        loss_est_q <= '0;
        jit_est_q  <= '0;
        rtt_est_q  <= '0;
        bw_est_q   <= '0;
      end
      // The first sample seeds the estimates directly.
      if ((state_q == ST_UPD) && first_q) begin
        first_q    <= 1'b0;
        loss_est_q <= cmd_q.loss;
        jit_est_q  <= cmd_q.jitter;
        rtt_est_q  <= cmd_q.rtt;
        bw_est_q   <= bw_smp_q;
      end
      if (state_q == ST_EAPPLY) begin
        case (idx_q)
          MET_LOSS:   loss_est_q <= new_val[LOSS_W-1:0];
          MET_JITTER: jit_est_q  <= new_val[JIT_W-1:0];
          MET_RTT:    rtt_est_q  <= new_val[RTT_W-1:0];
          MET_BW:     bw_est_q   <= new_val[BW_W-1:0];
          default:    bw_est_q   <= bw_est_q;
        endcase
      end
      // Output register handshake.
      if ((state_q == ST_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= head_i.cmd;
    end
    if ((state_q == ST_BWMUL) || (state_q == ST_EMUL)) begin
      prod_q <= prod_d;
    end
    if (state_q == ST_BWCHK) begin
      rem_q <= bw_high;
      quo_q <= prod_q[EST_W-1:0];
      if (cmd_q.zero_iv) begin
        bw_smp_q <= '0;
      end else if (bw_high >= cmd_q.us) begin
        bw_smp_q <= '1;
      end
    end
    if (state_q == ST_DIV) begin
      rem_q <= rem_next;
      quo_q <= quo_next;
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        bw_smp_q <= quo_next;
      end
    end
    if ((state_q == ST_EMIT) && out_free) begin
      loss_pct_q <= lpct_sum[LPCT_SHIFT +: LPCT_W];
      jit_out_q  <= jit_est_q;
      rtt_out_q  <= rtt_est_q;
      bw_out_q   <= bw_est_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign loss_pct_o       = loss_pct_q;
  assign jitter_est_o     = jit_out_q;
  assign rtt_est_o        = rtt_out_q;
  assign bandwidth_kbps_o = bw_out_q;

  // Checks.
  `LTES_ASSERT_IMP(a_pop_nonempty, pop_o, head_i.valid, "pop from an empty queue")
  `LTES_ASSERT_IMP(a_div_rem, state_q == ST_DIV, rem_q < cmd_q.us, "divider remainder too large")
  `LTES_ASSERT_NXT(a_emit_loads, (state_q == ST_EMIT) && out_free, out_valid_q, "result not shown")

endmodule

/* tb/sv/tb.sv */
// ============================================================================
// Link telemetry smoother testbench
// Drives link measurements and weight updates into the smoother, predicts the
// four smoothed estimates in step with every accepted item and checks each
// result in order, with random gaps on the input and stalls on the output.
// ============================================================================
`timescale 1ns / 1ps

module tb;
  import ltes_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned TAIL_CYCLES   = 100;
  localparam int unsigned SETTLE_CYCLES = 4;

  // What the sender does next: present an item, write the weight, or wait
  // until every outstanding result has come back.
  typedef enum logic [1:0] {
    ACT_ITEM,
    ACT_ALPHA,
    ACT_DRAIN
  } action_e;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } stall_mode_e;

  typedef struct {
    action_e            act;
    cmd_kind_e          kind;
    logic [LOSS_W-1:0]  loss;
    logic [JIT_W-1:0]   jitter;
    logic [RTT_W-1:0]   rtt;
    logic [BW_W-1:0]    bytes;
    logic [BW_W-1:0]    us;
    logic [ALPHA_W-1:0] alpha;
  } stim_t;

  typedef struct {
    logic [LPCT_W-1:0] loss_pct;
    logic [JIT_W-1:0]  jitter;
    logic [RTT_W-1:0]  rtt;
    logic [BW_W-1:0]   bw;
  } telemetry_t;

  // Block ports.
  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               alpha_we_i       = 1'b0;
  logic [ALPHA_W-1:0] alpha_wdata_i    = '0;
  logic               in_valid_i       = 1'b0;
  logic               in_stall_o;
  logic               clear_i          = 1'b0;
  logic [LOSS_W-1:0]  loss_rate_i      = '0;
  logic [JIT_W-1:0]   jitter_i         = '0;
  logic [RTT_W-1:0]   rtt_i            = '0;
  logic [BW_W-1:0]    bytes_received_i = '0;
  logic [BW_W-1:0]    interval_us_i    = '0;
  logic               out_valid_o;
  logic               out_stall_i      = 1'b0;
  logic [LPCT_W-1:0]  loss_pct_o;
  logic [JIT_W-1:0]   jitter_est_o;
  logic [RTT_W-1:0]   rtt_est_o;
  logic [BW_W-1:0]    bandwidth_kbps_o;

  // Stimulus plan and estimates still owed by the block.
  stim_t      schedule[$];
  telemetry_t pending_estimates[$];

  // Predicted state of the smoother.
  logic [ALPHA_W-1:0] weight_q  = ALPHA_RESET;
  logic [LOSS_W-1:0]  loss_avg  = '0;
  logic [JIT_W-1:0]   jit_avg   = '0;
  logic [RTT_W-1:0]   rtt_avg   = '0;
  logic [BW_W-1:0]    bw_avg    = '0;
  logic               seed_next = 1'b1;

  // Handshake and pacing state.
  logic        item_taken = 1'b0;
  int unsigned gap_left   = 0;
  int unsigned burst_left = 1;
  int unsigned quiet_cnt  = 0;
  stall_mode_e stall_mode = RX_OPEN;
  int unsigned stall_seg  = 0;

  // Run statistics.
  int unsigned cycle_cnt    = 0;
  int unsigned tail_cnt     = 0;
  int unsigned err_cnt      = 0;
  int unsigned n_items      = 0;
  int unsigned n_results    = 0;
  int unsigned n_clears     = 0;
  int unsigned n_zero_iv    = 0;
  int unsigned n_full_bw    = 0;
  int unsigned alpha_writes = 0;

  link_telemetry_ema_smoother u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .alpha_we_i       (alpha_we_i),
    .alpha_wdata_i    (alpha_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .clear_i          (clear_i),
    .loss_rate_i      (loss_rate_i),
    .jitter_i         (jitter_i),
    .rtt_i            (rtt_i),
    .bytes_received_i (bytes_received_i),
    .interval_us_i    (interval_us_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .loss_pct_o       (loss_pct_o),
    .jitter_est_o     (jitter_est_o),
    .rtt_est_o        (rtt_est_o),
    .bandwidth_kbps_o (bandwidth_kbps_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Bandwidth of one interval in kbit/s, zero for an empty interval and
  // clamped to the full 32-bit range.
  function automatic logic [BW_W-1:0] bandwidth_of(logic [BW_W-1:0] bytes,
                                                    logic [BW_W-1:0] us);
    logic [63:0] quot;
    if (us == '0) return '0;
    quot = (64'(bytes) * 64'd8000) / 64'(us);
    return (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
  endfunction

  // Moves an average toward a sample by weight/2^ALPHA_BITS of the distance,
  // truncating the step and keeping the result inside [0, top].
  function automatic logic [31:0] ema_move(logic [31:0] avg, logic [31:0] smp,
                                           logic [31:0] top, logic [15:0] w);
    logic [63:0] stride;
    logic [63:0] sum;
    if (smp >= avg) begin
      stride = (64'(w) * 64'(smp - avg)) >> ALPHA_BITS;
      sum = 64'(avg) + stride;
      return (sum > 64'(top)) ? top : sum[31:0];
    end
    stride = (64'(w) * 64'(avg - smp)) >> ALPHA_BITS;
    return (stride >= 64'(avg)) ? 32'd0 : avg - stride[31:0];
  endfunction

  // Applies one accepted item to the predicted state and returns the
  // estimates that the block must report for it.
  function automatic telemetry_t track_measurement(stim_t m);
    telemetry_t r;
    logic [BW_W-1:0] bw;
    logic [23:0] pct;
    if (m.kind == CMD_CLEAR) begin
      loss_avg  = '0;
      jit_avg   = '0;
      rtt_avg   = '0;
      bw_avg    = '0;
      seed_next = 1'b1;
    end else begin
      bw = bandwidth_of(m.bytes, m.us);
      if (seed_next) begin
        loss_avg  = m.loss;
        jit_avg   = m.jitter;
        rtt_avg   = m.rtt;
        bw_avg    = bw;
        seed_next = 1'b0;
      end else begin
        loss_avg = LOSS_W'(ema_move(32'(loss_avg), 32'(m.loss), 32'hFFFF, weight_q));
        jit_avg  = JIT_W'(ema_move(32'(jit_avg), 32'(m.jitter), 32'hF_FFFF, weight_q));
        rtt_avg  = RTT_W'(ema_move(32'(rtt_avg), 32'(m.rtt), 32'hF_FFFF, weight_q));
        bw_avg   = ema_move(bw_avg, bw, 32'hFFFF_FFFF, weight_q);
      end
    end
    pct = (24'(loss_avg) * 24'd100 + 24'd128) >> 8;
    r.loss_pct = pct[LPCT_W-1:0];
    r.jitter   = jit_avg;
    r.rtt      = rtt_avg;
    r.bw       = bw_avg;
    return r;
  endfunction

  // Value near a running center, with occasional extremes and full-range draws.
  function automatic logic [31:0] near(logic [31:0] c, logic [31:0] top);
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return top;
      2, 3:    return $urandom & top;
      default: return (c + $urandom_range(0, 512) - 32'd256) & top;
    endcase
  endfunction

  task automatic push_item(cmd_kind_e kind, logic [LOSS_W-1:0] loss,
                           logic [JIT_W-1:0] jit, logic [RTT_W-1:0] rtt,
                           logic [BW_W-1:0] bytes, logic [BW_W-1:0] us);
    stim_t s;
    s.act    = ACT_ITEM;
    s.kind   = kind;
    s.loss   = loss;
    s.jitter = jit;
    s.rtt    = rtt;
    s.bytes  = bytes;
    s.us     = us;
    s.alpha  = '0;
    schedule.push_back(s);
  endtask

  task automatic push_clear();
    push_item(CMD_CLEAR, LOSS_W'($urandom), JIT_W'($urandom), RTT_W'($urandom),
              $urandom, $urandom);
  endtask

  task automatic push_action(action_e act, logic [ALPHA_W-1:0] alpha);
    stim_t s;
    s.act    = act;
    s.kind   = CMD_SAMPLE;
    s.loss   = '0;
    s.jitter = '0;
    s.rtt    = '0;
    s.bytes  = '0;
    s.us     = '0;
    s.alpha  = alpha;
    schedule.push_back(s);
  endtask

  // Build the whole plan, then release reset.
  initial begin
    logic [ALPHA_W-1:0] w;
    logic [31:0] loss_c, jit_c, rtt_c, bytes_c, us_c;
    logic [31:0] us;

    // Directed part at the reset weight: seeding with full-scale samples,
    // bandwidth saturation, zero intervals, and clears back to back.
    push_item(CMD_SAMPLE, 16'hFFFF, 20'hF_FFFF, 20'hF_FFFF, 32'hFFFF_FFFF, 32'd1);
    push_item(CMD_SAMPLE, 16'h0000, 20'h0_0000, 20'h0_0000, 32'd0, 32'd0);
    push_item(CMD_SAMPLE, 16'h0000, 20'h0_0000, 20'h0_0000, 32'hFFFF_FFFF, 32'd0);
    push_item(CMD_SAMPLE, 16'd8000, 20'd12345, 20'd54321, 32'd1000, 32'd8000);
    push_clear();
    push_item(CMD_SAMPLE, 16'd1, 20'd1, 20'd1, 32'd125, 32'd1);
    push_item(CMD_SAMPLE, 16'd100, 20'd160, 20'd800, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Quotients just past and just below the 32-bit limit.
    push_item(CMD_SAMPLE, 16'd32768, 20'd80000, 20'd16, 32'd536870912, 32'd1000);
    push_item(CMD_SAMPLE, 16'd32768, 20'd80000, 20'd16, 32'd536870911, 32'd1000);
    push_clear();
    push_clear();
    push_item(CMD_SAMPLE, 16'h0000, 20'h0_0000, 20'h0_0000, 32'd0, 32'd0);
    push_item(CMD_SAMPLE, 16'hFFFF, 20'hF_FFFF, 20'hF_FFFF, 32'hFFFF_FFFF, 32'd1);

    // A zero weight freezes the estimates once seeded.
    push_action(ACT_ALPHA, 16'h0000);
    push_item(CMD_SAMPLE, 16'd1234, 20'd4321, 20'd99999, 32'd777777, 32'd333);
    push_item(CMD_SAMPLE, 16'h0000, 20'h0_0000, 20'h0_0000, 32'd0, 32'd0);
    push_clear();
    push_item(CMD_SAMPLE, 16'd4000, 20'd5000, 20'd6000, 32'd7000, 32'd8000);
    push_item(CMD_SAMPLE, 16'hFFFF, 20'hF_FFFF, 20'hF_FFFF, 32'hFFFF_FFFF, 32'd1);

    // The largest weight tracks the sample almost fully.
    push_action(ACT_ALPHA, 16'hFFFF);
    push_item(CMD_SAMPLE, 16'hFFFF, 20'hF_FFFF, 20'hF_FFFF, 32'hFFFF_FFFF, 32'd1);
    push_item(CMD_SAMPLE, 16'h0000, 20'h0_0000, 20'h0_0000, 32'd0, 32'd0);
    push_item(CMD_SAMPLE, 16'h5555, 20'hA_AAAA, 20'h5_5555, 32'hAAAA_5555, 32'd4096);

    // Random phases, each under its own weight. Samples mostly wander around
    // centers that move every few dozen items, so the averages are pulled
    // both up and down; full-range values, extremes and clears are mixed in.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       w = 16'h0000;
        1:       w = 16'hFFFF;
        2:       w = ALPHA_RESET;
        3:       w = 16'd1;
        default: w = ALPHA_W'($urandom);
      endcase
      push_action(ACT_ALPHA, w);
      for (int n = 0; n < 240; n++) begin
        if (n % 32 == 0) begin
          loss_c  = $urandom_range(0, 65535);
          jit_c   = $urandom & 32'hF_FFFF;
          rtt_c   = $urandom & 32'hF_FFFF;
          bytes_c = $urandom_range(0, 50_000_000);
          us_c    = $urandom_range(1000, 2_000_000);
        end
        if (n == 120) push_action(ACT_DRAIN, '0);
        if ($urandom_range(0, 24) == 0) begin
          push_clear();
        end else begin
          case ($urandom_range(0, 9))
            0:       us = 32'd0;
            1:       us = $urandom;
            2:       us = $urandom_range(1, 16);
            3:       us = $urandom_range(1, 1000);
            default: us = near(us_c, 32'hFFFF_FFFF);
          endcase
          push_item(CMD_SAMPLE, LOSS_W'(near(loss_c, 32'hFFFF)),
                    JIT_W'(near(jit_c, 32'hF_FFFF)), RTT_W'(near(rtt_c, 32'hF_FFFF)),
                    near(bytes_c, 32'hFFFF_FFFF), us);
        end
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Sender: presents one planned step at a time in bursts with gaps, holds a
  // presented item until it is taken, and writes the weight only when the
  // block has gone quiet.
  always @(negedge clk_i) begin
    stim_t s;
    logic nv;
    logic nwe;
    nv  = 1'b0;
    nwe = 1'b0;
    quiet_cnt = (pending_estimates.size() == 0) ? quiet_cnt + 1 : 0;
    if (rst_ni && !(in_valid_i && !item_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (schedule.size() != 0) begin
        s = schedule[0];
        case (s.act)
          ACT_ITEM: begin
            nv = 1'b1;
            clear_i          <= (s.kind == CMD_CLEAR);
            loss_rate_i      <= s.loss;
            jitter_i         <= s.jitter;
            rtt_i            <= s.rtt;
            bytes_received_i <= s.bytes;
            interval_us_i    <= s.us;
            void'(schedule.pop_front());
            if (burst_left > 1) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(1, 30);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
          end
          ACT_ALPHA: begin
            if (quiet_cnt >= SETTLE_CYCLES) begin
              nwe = 1'b1;
              alpha_wdata_i <= s.alpha;
              void'(schedule.pop_front());
            end
          end
          default: begin
            if (pending_estimates.size() == 0) void'(schedule.pop_front());
          end
        endcase
      end
      in_valid_i <= nv;
      alpha_we_i <= nwe;
    end
  end

  // Receiver: switches to a randomly chosen stall pattern after each segment of random length.
  always @(negedge clk_i) begin
    if (stall_seg == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_seg  = $urandom_range(16, 400);
    end
    stall_seg--;
    case (stall_mode)
      RX_OPEN:  out_stall_i <= 1'b0;
      RX_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:  out_stall_i <= ((stall_seg % 16) < 12);
    endcase
  end

  // Monitor: tracks weight writes and accepted items, checks every result
  // against the oldest owed estimate, and ends the run.
  always @(posedge clk_i) begin
    stim_t seen;
    telemetry_t want;
    if (rst_ni) begin
      cycle_cnt++;
      if (alpha_we_i) begin
        weight_q = alpha_wdata_i;
        alpha_writes++;
      end

      // Accepted item: predict its result.
      item_taken = in_valid_i && !in_stall_o;
      if (item_taken) begin
        seen.act    = ACT_ITEM;
        seen.kind   = clear_i ? CMD_CLEAR : CMD_SAMPLE;
        seen.loss   = loss_rate_i;
        seen.jitter = jitter_i;
        seen.rtt    = rtt_i;
        seen.bytes  = bytes_received_i;
        seen.us     = interval_us_i;
        seen.alpha  = '0;
        n_items++;
        if (seen.kind == CMD_CLEAR) n_clears++;
        else if (seen.us == '0) n_zero_iv++;
        else if (bandwidth_of(seen.bytes, seen.us) == 32'hFFFF_FFFF) n_full_bw++;
        pending_estimates.push_back(track_measurement(seen));
      end

      // Accepted result: compare field by field.
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (pending_estimates.size() == 0) begin
          $error("result with no item outstanding");
          err_cnt++;
        end else begin
          want = pending_estimates.pop_front();
          if (loss_pct_o !== want.loss_pct) begin
            $error("loss_pct: expected %0d, got %0d", want.loss_pct, loss_pct_o);
            err_cnt++;
          end
          if (jitter_est_o !== want.jitter) begin
            $error("jitter_est: expected %0d, got %0d", want.jitter, jitter_est_o);
            err_cnt++;
          end
          if (rtt_est_o !== want.rtt) begin
            $error("rtt_est: expected %0d, got %0d", want.rtt, rtt_est_o);
            err_cnt++;
          end
          if (bandwidth_kbps_o !== want.bw) begin
            $error("bandwidth_kbps: expected %0d, got %0d", want.bw, bandwidth_kbps_o);
            err_cnt++;
          end
        end
      end

      // Once everything is sent and answered, watch a while for stray results.
      tail_cnt = (schedule.size() == 0 && !in_valid_i && pending_estimates.size() == 0)
                 ? tail_cnt + 1 : 0;
      if (tail_cnt == TAIL_CYCLES) begin
        $display("Sent %0d items (%0d clears, %0d zero intervals, %0d full-scale rates)",
                 n_items, n_clears, n_zero_iv, n_full_bw);
        $display("under %0d weight settings; %0d results checked in %0d cycles.",
                 alpha_writes + 1, n_results, cycle_cnt);
        if (err_cnt == 0) begin
          $display("PASS");
        end else begin
          $display("FAIL");
        end
        $finish;
      end else if (cycle_cnt == CYCLE_LIMIT) begin
        $display("Timed out with %0d results outstanding.", pending_estimates.size());
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/ltes_pkg.sv
hw/rtl/ltes_front.sv
hw/rtl/ltes_back.sv
hw/rtl/link_telemetry_ema_smoother.sv
tb/sv/tb.sv
